// ----- hw/rtl/ldf_pkg.sv -----
// Package of shared types and constants for the link packet deframer.
package ldf_pkg;

  localparam int unsigned POINTS_DEF      = 160;
  localparam int unsigned MAX_PAYLOAD_DEF = 512;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] SYNC_BYTE  = 8'hA5;
  localparam logic [7:0] CMD_PARAMS = 8'h61;
  localparam logic [7:0] CMD_SCAN   = 8'h63;
  localparam logic [7:0] CMD_STOP   = 8'h64;
  localparam logic [15:0] DIST_MASK = 16'h01FF;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CMD,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    K_DIST      = 3'd0,
    K_SCAN_OK   = 3'd1,
    K_START_ACK = 3'd2,
    K_STOP_ACK  = 3'd3,
    K_PARAMS    = 3'd4,
    K_CSUM_BAD  = 3'd5,
    K_OTHER_OK  = 3'd6,
    K_TOO_LONG  = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_PARAM_LO,
    OP_PARAM_HI,
    OP_BIAS
  } op_e;

  // One queued operation handed from the parser to the result stage.
  typedef struct packed {
    op_e         op;
    kind_e       kind;
    logic [7:0]  idx;
    logic [8:0]  dist_val;
    logic [7:0]  cmd;
    logic [7:0]  data;
    logic [1:0]  word;
  } op_t;

endpackage

// ----- hw/rtl/ldf_if.sv -----
// Handshake interfaces for the received byte channel and the result channel.
interface ldf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ldf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  point_index;
  logic [8:0]  distance;
  logic [7:0]  command_code;
  logic [15:0] comp_k0;
  logic [15:0] comp_b0;
  logic [15:0] comp_k1;
  logic [15:0] comp_b1;
  logic [7:0]  bias_raw;
  logic        scanning;
  logic        last;

  modport source (
    output valid, output kind, output point_index, output distance,
    output command_code, output comp_k0, output comp_b0, output comp_k1,
    output comp_b1, output bias_raw, output scanning, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input point_index, input distance,
    input command_code, input comp_k0, input comp_b0, input comp_k1,
    input comp_b1, input bias_raw, input scanning, input last,
    output ready
  );
endinterface

// ----- hw/rtl/ldf_front.sv -----
// Packet parser: follows the frame byte by byte and queues operations.
module ldf_front import ldf_pkg::*; #(
  parameter int unsigned POINTS      = POINTS_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ldf_byte_if.sink    rx_i,
  input  logic        q_full_i,
  output logic        push_o,
  output op_t         push_op_o
);

  localparam logic [8:0] PointsW = 9'(POINTS);
  localparam logic [8:0] HalfW   = 9'(POINTS / 2);

  phase_e      phase_q, phase_d;
  logic [2:0]  pre_cnt_q, pre_cnt_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  pc_q, pc_d;

  logic        accept;
  logic [7:0]  b;
  logic [15:0] len_full;
  logic [15:0] off_next;
  logic [8:0]  idx_raw;
  logic [8:0]  idx_wrap;
  logic [15:0] dist_word;

  assign rx_i.ready = !q_full_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign len_full   = {b, len_q[7:0]};
  assign off_next   = byte_cnt_q + 16'd1;
  assign idx_raw    = {1'b0, pc_q} + HalfW;
  assign idx_wrap   = (idx_raw >= PointsW) ? (idx_raw - PointsW) : idx_raw;
  assign dist_word  = {b, low_q} & DIST_MASK;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == SYNC_BYTE && pre_cnt_q == 3'd3) phase_d = PH_ADDR;
        end
        PH_ADDR:   phase_d = PH_CMD;
        PH_CMD:    phase_d = PH_LEN_LO;
        PH_LEN_LO: phase_d = PH_LEN_HI;
        PH_LEN_HI: begin
          if (len_full > 16'(MAX_PAYLOAD)) phase_d = PH_HUNT;
          else if (len_full == 16'd0)      phase_d = PH_CHECK;
          else                             phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (off_next >= len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: phase_d = PH_HUNT;
        default:  phase_d = PH_HUNT;
      endcase
    end
  end

  // Datapath registers and queued operations.
  always_comb begin
    pre_cnt_d  = pre_cnt_q;
    byte_cnt_d = byte_cnt_q;
    len_d      = len_q;
    sum_d      = sum_q;
    cmd_d      = cmd_q;
    low_d      = low_q;
    pc_d       = pc_q;
    push_o     = 1'b0;
    push_op_o  = '{op: OP_EMIT, kind: K_DIST, idx: 8'd0, dist_val: 9'd0,
                   cmd: cmd_q, data: b, word: byte_cnt_q[2:1]};
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == SYNC_BYTE && pre_cnt_q != 3'd3) pre_cnt_d = pre_cnt_q + 3'd1;
          else                                     pre_cnt_d = 3'd0;
        end
        PH_ADDR: sum_d = b;
        PH_CMD: begin
          cmd_d = b;
          sum_d = sum_q + b;
        end
        PH_LEN_LO: begin
          len_d = {8'd0, b};
          sum_d = sum_q + b;
        end
        PH_LEN_HI: begin
          len_d      = len_full;
          sum_d      = sum_q + b;
          byte_cnt_d = 16'd0;
          pc_d       = 8'd0;
          if (len_full > 16'(MAX_PAYLOAD)) begin
            push_o         = 1'b1;
            push_op_o.kind = K_TOO_LONG;
          end
        end
        PH_PAYLOAD: begin
          sum_d      = sum_q + b;
          byte_cnt_d = off_next;
          if (cmd_q == CMD_SCAN && byte_cnt_q >= 16'd2) begin
            if (!byte_cnt_q[0]) begin
              low_d = b;
            end else if (pc_q < 8'(POINTS)) begin
              pc_d               = pc_q + 8'd1;
              push_o             = 1'b1;
              push_op_o.idx      = idx_wrap[7:0];
              push_op_o.dist_val = dist_word[8:0];
            end
          end else if (cmd_q == CMD_PARAMS) begin
            if (byte_cnt_q < 16'd8) begin
              push_o       = 1'b1;
              push_op_o.op = byte_cnt_q[0] ? OP_PARAM_HI : OP_PARAM_LO;
            end else if (byte_cnt_q == 16'd8) begin
              push_o       = 1'b1;
              push_op_o.op = OP_BIAS;
            end
          end
        end
        PH_CHECK: begin
          push_o = 1'b1;
          if (b != sum_q)             push_op_o.kind = K_CSUM_BAD;
          else if (cmd_q == CMD_PARAMS) push_op_o.kind = K_PARAMS;
          else if (cmd_q == CMD_SCAN)
            push_op_o.kind = (len_q == 16'd0) ? K_START_ACK : K_SCAN_OK;
          else if (cmd_q == CMD_STOP) push_op_o.kind = K_STOP_ACK;
          else                        push_op_o.kind = K_OTHER_OK;
        end
        default: pre_cnt_d = 3'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      pre_cnt_q  <= 3'd0;
      byte_cnt_q <= 16'd0;
      len_q      <= 16'd0;
      sum_q      <= 8'd0;
      cmd_q      <= 8'd0;
      low_q      <= 8'd0;
      pc_q       <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      pre_cnt_q  <= pre_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      cmd_q      <= cmd_d;
      low_q      <= low_d;
      pc_q       <= pc_d;
    end
  end

endmodule

// ----- hw/rtl/ldf_fifo.sv -----
// Short operation queue between the parser and the result stage.
module ldf_fifo import ldf_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  input  logic pop_i,
  output op_t  head_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  op_t             mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/ldf_back.sv -----
// Result stage: applies queued operations and drives the result register.
module ldf_back import ldf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        head_i,
  input  logic       empty_i,
  output logic       pop_o,
  ldf_res_if.source  res_o
);

  logic [15:0] words_q [4];
  logic [7:0]  bias_q;
  logic        scan_q, scan_d;
  logic        out_vld_q;
  logic        emit;
  logic        is_params;

  logic [2:0]  kind_q;
  logic [7:0]  idx_q, cmd_q, bias_out_q;
  logic [8:0]  dist_q;
  logic [15:0] k0_q, b0_q, k1_q, b1_q;
  logic        scanning_q, last_q;

  assign pop_o = !empty_i && (head_i.op != OP_EMIT || !out_vld_q || res_o.ready);
  assign emit  = pop_o && head_i.op == OP_EMIT;
  assign is_params = (head_i.kind == K_PARAMS);

  always_comb begin
    scan_d = scan_q;
    if (emit) begin
      if (head_i.kind == K_START_ACK)     scan_d = 1'b1;
      else if (head_i.kind == K_STOP_ACK) scan_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q   <= '{default: 16'd0};
      bias_q    <= 8'd0;
      scan_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      scan_q <= scan_d;
      if (pop_o) begin
        case (head_i.op)
          OP_PARAM_LO: words_q[head_i.word][7:0]  <= head_i.data;
          OP_PARAM_HI: words_q[head_i.word][15:8] <= head_i.data;
          OP_BIAS:     bias_q <= head_i.data;
          default:     ;
        endcase
      end
      if (emit)             out_vld_q <= 1'b1;
      else if (res_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q     <= head_i.kind;
      idx_q      <= head_i.idx;
      dist_q     <= head_i.dist_val;
      cmd_q      <= head_i.cmd;
      k0_q       <= is_params ? words_q[0] : 16'd0;
      b0_q       <= is_params ? words_q[1] : 16'd0;
      k1_q       <= is_params ? words_q[2] : 16'd0;
      b1_q       <= is_params ? words_q[3] : 16'd0;
      bias_out_q <= is_params ? bias_q : 8'd0;
      scanning_q <= scan_d;
      last_q     <= (head_i.kind != K_DIST);
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.kind         = kind_q;
  assign res_o.point_index  = idx_q;
  assign res_o.distance     = dist_q;
  assign res_o.command_code = cmd_q;
  assign res_o.comp_k0      = k0_q;
  assign res_o.comp_b0      = b0_q;
  assign res_o.comp_k1      = k1_q;
  assign res_o.comp_b1      = b1_q;
  assign res_o.bias_raw     = bias_out_q;
  assign res_o.scanning     = scanning_q;
  assign res_o.last         = last_q;

endmodule

// ----- hw/rtl/lidar_frame_deframer.sv -----
// Top level of the link packet deframer: parser, operation queue, result stage.
//
// The deframer takes one received link byte per word on rx_i and accepts a new
// word in every clock cycle while its internal operation queue has room; the
// queue is QUEUE_DEPTH entries deep and only fills when the result channel
// res_o is held off, so with a free-flowing sink the rate is one byte per
// cycle. The parser hunts for four 0xA5 bytes, then reads address, command
// and a little-endian length, and keeps an 8-bit sum from the address byte up
// to the last payload byte. Scan packets give provisional distance words as
// their point pairs arrive (the first two payload bytes are skipped and only
// the first POINTS pairs count); each packet ends in one verdict word with
// last set, telling whether the checksum matched and, for start and stop
// acknowledgements, updating the scanning flag. A length above MAX_PAYLOAD
// is reported at once and hunting restarts. A result word is held first in
// the queue and then in the output register before it shows on res_o.
module lidar_frame_deframer import ldf_pkg::*; #(
  parameter int unsigned POINTS      = POINTS_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ldf_byte_if.sink   rx_i,
  ldf_res_if.source  res_o
);

  // Parser to queue.
  logic push;
  op_t  push_op;
  logic q_full;

  // Queue to result stage.
  op_t  head;
  logic q_empty;
  logic pop;

  ldf_front #(
    .POINTS      (POINTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .push_op_o (push_op)
  );

  // Parameter writes pass through the queue too, so they stay in order with
  // the verdict that reports them.
  ldf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  ldf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
